### rtl/riff_chunk_payload_extractor_core_macros.svh
// -----------------------------------------------------------------------------
// RIFF chunk payload extractor - assertion macros
// Shared concurrent assertion shorthands, clocked on clk and off in reset.
// -----------------------------------------------------------------------------
`ifndef RIFF_CHUNK_PAYLOAD_EXTRACTOR_CORE_MACROS_SVH
`define RIFF_CHUNK_PAYLOAD_EXTRACTOR_CORE_MACROS_SVH

// same-cycle implication
`define RCPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rcpe_pkg.sv
// -----------------------------------------------------------------------------
// RIFF chunk payload extractor - package
// Word types, phase and outcome codes and fixed format constants.
// -----------------------------------------------------------------------------
package rcpe_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_word_t;

    typedef enum logic [2:0] {
        OUT_RUNNING   = 3'd0,
        OUT_COMPLETE  = 3'd1,
        OUT_NOT_RIFF  = 3'd2,
        OUT_NOT_FOUND = 3'd3,
        OUT_TRUNCATED = 3'd4,
        OUT_TOO_SMALL = 3'd5
    } outcome_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        outcome_t   outcome;
        logic       finished;
    } out_word_t;

    typedef enum logic [2:0] {
        PH_RIFF    = 3'd0,
        PH_CHDR    = 3'd1,
        PH_SKIP    = 3'd2,
        PH_PAD     = 3'd3,
        PH_VERSION = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic {
        CFG_CONTAINER_ID    = 1'b0,
        CFG_TARGET_CHUNK_ID = 1'b1
    } cfg_index_t;

    localparam logic [31:0] CONTAINER_ID_RESET    = 32'h4646_4952;
    localparam logic [31:0] TARGET_CHUNK_ID_RESET = 32'h4B48_4350;

    localparam logic [3:0]  RIFF_HEADER_BYTES  = 4'd12;
    localparam logic [3:0]  CHUNK_HEADER_BYTES = 4'd8;
    localparam logic [3:0]  ID_BYTES           = 4'd4;
    localparam logic [31:0] VERSION_BYTES      = 32'd4;

endpackage

### rtl/rcpe_in_stage.sv
// -----------------------------------------------------------------------------
// RIFF chunk payload extractor - input register
// Holds one accepted byte word until the parser steps on it.
// -----------------------------------------------------------------------------
module rcpe_in_stage
    import rcpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_word_t word_in,
    input  logic     step,
    output logic     held_valid,
    output in_word_t held_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

### rtl/rcpe_parser.sv
// -----------------------------------------------------------------------------
// RIFF chunk payload extractor - parser
// Configuration registers, chunk walk state and the per-byte step logic.
// -----------------------------------------------------------------------------
module rcpe_parser
    import rcpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  step,
    input  in_word_t              word_in,
    output logic                  result_load,
    output out_word_t             result_word
);

    logic [31:0] container_id_reg;
    logic [31:0] target_id_reg;

    phase_t      phase_reg,     phase_next;
    logic [3:0]  hdr_count_reg, hdr_count_next;
    logic [31:0] id_shift_reg,  id_shift_next;
    logic [31:0] size_shift_reg, size_shift_next;
    logic [31:0] remaining_reg, remaining_next;
    logic        pad_reg,       pad_next;

    logic [3:0]  count_inc;
    logic [31:0] id_in;
    logic [31:0] size_in;
    logic [31:0] remaining_dec;
    logic        eof;
    logic        fin;
    logic        has;
    outcome_t    outc;
    logic        ignore;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            container_id_reg <= CONTAINER_ID_RESET;
            target_id_reg    <= TARGET_CHUNK_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONTAINER_ID:    container_id_reg <= cfg_data;
                CFG_TARGET_CHUNK_ID: target_id_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign eof           = word_in.end_of_file;
    assign count_inc     = hdr_count_reg + 4'd1;
    assign id_in         = {word_in.file_byte, id_shift_reg[31:8]};
    assign size_in       = {word_in.file_byte, size_shift_reg[31:8]};
    assign remaining_dec = (remaining_reg != 32'd0) ? remaining_reg - 32'd1 : remaining_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_count_next  = hdr_count_reg;
        id_shift_next   = id_shift_reg;
        size_shift_next = size_shift_reg;
        remaining_next  = remaining_reg;
        pad_next        = pad_reg;
        fin             = 1'b0;
        has             = 1'b0;
        outc            = OUT_RUNNING;
        ignore          = 1'b0;

        case (phase_reg)
            PH_RIFF:
            begin
                hdr_count_next = count_inc;
                if (count_inc <= ID_BYTES)
                begin
                    id_shift_next = id_in;
                end
                if (count_inc == ID_BYTES && id_in != container_id_reg)
                begin
                    fin  = 1'b1;
                    outc = OUT_NOT_RIFF;
                end
                else if (count_inc >= RIFF_HEADER_BYTES)
                begin
                    hdr_count_next = 4'd0;
                    phase_next     = PH_CHDR;
                    if (eof)
                    begin
                        fin  = 1'b1;
                        outc = OUT_NOT_FOUND;
                    end
                end
                else if (eof)
                begin
                    fin  = 1'b1;
                    outc = OUT_NOT_RIFF;
                end
            end
            PH_CHDR:
            begin
                hdr_count_next = count_inc;
                if (count_inc <= ID_BYTES)
                begin
                    id_shift_next = id_in;
                end
                else
                begin
                    size_shift_next = size_in;
                end
                if (count_inc >= CHUNK_HEADER_BYTES)
                begin
                    hdr_count_next = 4'd0;
                    if (id_shift_reg == target_id_reg)
                    begin
                        if (size_in <= VERSION_BYTES)
                        begin
                            fin  = 1'b1;
                            outc = OUT_TOO_SMALL;
                        end
                        else
                        begin
                            remaining_next = VERSION_BYTES;
                            phase_next     = PH_VERSION;
                            if (eof)
                            begin
                                fin  = 1'b1;
                                outc = OUT_TRUNCATED;
                            end
                        end
                    end
                    else
                    begin
                        remaining_next = size_in;
                        pad_next       = size_in[0];
                        phase_next     = (size_in != 32'd0) ? PH_SKIP : PH_CHDR;
                        if (eof)
                        begin
                            fin  = 1'b1;
                            outc = OUT_NOT_FOUND;
                        end
                    end
                end
                else if (eof)
                begin
                    fin  = 1'b1;
                    outc = OUT_NOT_FOUND;
                end
            end
            PH_SKIP:
            begin
                remaining_next = remaining_dec;
                if (remaining_dec == 32'd0)
                begin
                    phase_next = pad_reg ? PH_PAD : PH_CHDR;
                end
                if (eof)
                begin
                    fin  = 1'b1;
                    outc = OUT_NOT_FOUND;
                end
            end
            PH_PAD:
            begin
                pad_next   = 1'b0;
                phase_next = PH_CHDR;
                if (eof)
                begin
                    fin  = 1'b1;
                    outc = OUT_NOT_FOUND;
                end
            end
            PH_VERSION:
            begin
                remaining_next = remaining_dec;
                if (remaining_dec == 32'd0)
                begin
                    remaining_next = size_shift_reg - VERSION_BYTES;
                    phase_next     = PH_PAYLOAD;
                end
                if (eof)
                begin
                    fin  = 1'b1;
                    outc = OUT_TRUNCATED;
                end
            end
            PH_PAYLOAD:
            begin
                has            = 1'b1;
                remaining_next = remaining_dec;
                if (remaining_dec == 32'd0)
                begin
                    fin  = 1'b1;
                    outc = OUT_COMPLETE;
                end
                else if (eof)
                begin
                    fin  = 1'b1;
                    outc = OUT_TRUNCATED;
                end
            end
            default:
            begin
                ignore = 1'b1;
            end
        endcase

        // finish: restart for the next file at end of file, else wait in the done phase
        if (fin || (ignore && eof))
        begin
            phase_next      = eof ? PH_RIFF : PH_DONE;
            hdr_count_next  = 4'd0;
            id_shift_next   = 32'd0;
            size_shift_next = 32'd0;
            remaining_next  = 32'd0;
            pad_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RIFF;
            hdr_count_reg  <= 4'd0;
            id_shift_reg   <= 32'd0;
            size_shift_reg <= 32'd0;
            remaining_reg  <= 32'd0;
            pad_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            hdr_count_reg  <= hdr_count_next;
            id_shift_reg   <= id_shift_next;
            size_shift_reg <= size_shift_next;
            remaining_reg  <= remaining_next;
            pad_reg        <= pad_next;
        end
    end

    assign result_load              = step && (fin || has);
    assign result_word.payload_byte = has ? word_in.file_byte : 8'd0;
    assign result_word.has_byte     = has;
    assign result_word.outcome      = outc;
    assign result_word.finished     = fin;

endmodule

### rtl/rcpe_out_stage.sv
// -----------------------------------------------------------------------------
// RIFF chunk payload extractor - result register
// Holds one result word for the consumer and reports when it can take another.
// -----------------------------------------------------------------------------
module rcpe_out_stage
    import rcpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t word_in,
    input  logic      ready,
    output logic      valid,
    output out_word_t word_out,
    output logic      free
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_in;
        end
    end

    assign valid    = valid_reg;
    assign word_out = word_reg;

endmodule

### rtl/riff_chunk_payload_extractor_core.sv
// Path: an accepted byte word is held in the input register, its result word in the result register.
// Throughput: one byte word per cycle while the result register is free; the chunk walk state updates once per byte.
// Bytes that cause no result still take one step and produce nothing.
// Reset: asynchronous, active low; returns to the RIFF header phase and
// restores the default container and target chunk ids.
// -----------------------------------------------------------------------------
// RIFF chunk payload extractor - top level
// Input register, per-byte parser and result register in one pass.
// -----------------------------------------------------------------------------
`include "riff_chunk_payload_extractor_core_macros.svh"

module riff_chunk_payload_extractor_core
    import rcpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  in_word_t              byte_word,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_word_t             result_word
);

    logic      held_valid;
    in_word_t  held_word;
    logic      step;
    logic      out_free;
    logic      res_load;
    out_word_t res_word;

    assign step       = held_valid && out_free;
    assign byte_ready = !held_valid || step;

    rcpe_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (byte_valid && byte_ready),
        .word_in    (byte_word),
        .step       (step),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    rcpe_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (step),
        .word_in     (held_word),
        .result_load (res_load),
        .result_word (res_word)
    );

    rcpe_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .word_in  (res_word),
        .ready    (result_ready),
        .valid    (result_valid),
        .word_out (result_word),
        .free     (out_free)
    );

    `RCPE_ASSERT_IMP(a_running_outcome, result_valid && !result_word.finished, result_word.outcome == OUT_RUNNING, "outcome set on a result that does not finish")
    `RCPE_ASSERT_IMP(a_no_empty_result, result_valid && !result_word.finished, result_word.has_byte, "result word carries neither byte nor outcome")
    `RCPE_ASSERT_IMP(a_idle_byte_zero, result_valid && !result_word.has_byte, result_word.payload_byte == 8'd0, "payload byte nonzero without has_byte")
    `RCPE_ASSERT_NEXT(a_load_shows, res_load, result_valid, "loaded result word not presented")

endmodule
